/* rtl/timestamped_ring_recall_defines.svh */
// Assertion macros for the timestamped ring recall block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TIMESTAMPED_RING_RECALL_DEFINES_SVH
`define TIMESTAMPED_RING_RECALL_DEFINES_SVH

`ifndef SYNTHESIS
`define TRR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trr: implication check failed");
`define TRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trr: next-cycle check failed");
`else
`define TRR_ASSERT_IMP(label, ante, cons)
`define TRR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/trr_pkg.sv */
// Shared types and constants for the timestamped ring recall block.
// No dependencies.
`default_nettype none

package trr_pkg;

    localparam int DEPTH_DEFAULT         = 16;
    localparam int PAYLOAD_WIDTH_DEFAULT = 64;

    localparam int ACTION_W      = 2;
    localparam int STAMP_W       = 32;
    localparam int AGE_W         = 16;
    localparam int RING_LEN_W    = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [RING_LEN_W-1:0] RING_LEN_RESET = 5'd16;
    localparam logic [AGE_W-1:0]      MAX_AGE_RESET  = 16'd100;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RECALL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_RING_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_AGE     = 2'd1;

    typedef struct packed {
        logic accept;
        logic later;
    } match_t;

endpackage

`default_nettype wire

/* rtl/trr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module trr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/trr_match.sv */
// Shared stamp compare unit: one subtract gives both the age test and the later test.
// Depends on trr_pkg.
`default_nettype none

module trr_match (
    input  wire logic [trr_pkg::STAMP_W-1:0] stamp,
    input  wire logic                        stamp_valid,
    input  wire logic [trr_pkg::STAMP_W-1:0] query,
    input  wire logic [trr_pkg::AGE_W-1:0]   max_age,
    output trr_pkg::match_t                  result
);
    import trr_pkg::*;

    logic [STAMP_W-1:0] stamp_eff;
    logic [STAMP_W:0]   diff;

    always_comb
    begin
        stamp_eff     = stamp_valid ? stamp : '0;
        diff          = {1'b0, query} - {1'b0, stamp_eff};
        result.later  = diff[STAMP_W];
        result.accept = (stamp_eff != '0) && !diff[STAMP_W]
                        && (diff[STAMP_W-1:0] < STAMP_W'(max_age));
    end

endmodule

`default_nettype wire

/* rtl/timestamped_ring_recall.sv */
// Ring of time-stamped observations with recall by query time (top level).
// Depends on trr_pkg, trr_ram, trr_match and timestamped_ring_recall_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries action, stamp_ms, payload and
//   query_time_ms. Every transaction yields exactly one result transaction on
//   out_valid/out_ready (found, out_stamp_ms, out_payload).
//   Push, clear and unused actions: the result is registered via EXEC and DONE.
//   Recall: k (1..DEPTH) is the number of entries walked; each entry takes a
//   RAM read (READ) and then a test in the shared compare unit (EVAL), then
//   COMMIT and DONE follow. A recall with no new data goes from EXEC to DONE.
//   in_ready is high only between items; one item is in flight at a time.
//   The result sits in an output register; the next item is accepted while it
//   waits. If the receiver stalls, a finished item holds in its last state
//   until the output register frees up.
//   Configuration port (cfg_valid/cfg_ready, always ready): index 0 is
//   ring_length, index 1 is max_age_ms; write only while idle.
//   Reset: store reads empty (per-entry valid bits cleared), pointers and the
//   new-data flag at zero, ring_length 16, max_age_ms 100. No clearing pass.
`default_nettype none
`include "timestamped_ring_recall_defines.svh"

module timestamped_ring_recall #(
    parameter int DEPTH         = trr_pkg::DEPTH_DEFAULT,
    parameter int PAYLOAD_WIDTH = trr_pkg::PAYLOAD_WIDTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [trr_pkg::ACTION_W-1:0]    action,
    input  wire logic [trr_pkg::STAMP_W-1:0]     stamp_ms,
    input  wire logic [PAYLOAD_WIDTH-1:0]        payload,
    input  wire logic [trr_pkg::STAMP_W-1:0]     query_time_ms,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 found,
    output logic      [trr_pkg::STAMP_W-1:0]     out_stamp_ms,
    output logic      [PAYLOAD_WIDTH-1:0]        out_payload,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [trr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [trr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import trr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = (PTR_W + 1 > RING_LEN_W + 1) ? PTR_W + 1 : RING_LEN_W + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]               state_reg;
    logic [ACTION_W-1:0]      act_reg;
    logic [STAMP_W-1:0]       stamp_in_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_in_reg;
    logic [STAMP_W-1:0]       qt_reg;
    logic [PTR_W-1:0]         head_reg;
    logic [PTR_W-1:0]         tail_reg;
    logic [PTR_W-1:0]         walk_reg;
    logic [PTR_W-1:0]         cnt_reg;
    logic [PTR_W-1:0]         best_reg;
    logic                     hit_reg;
    logic                     single_reg;
    logic                     flag_reg;
    logic [DEPTH-1:0]         valid_reg;
    logic [STAMP_W-1:0]       best_stamp_reg;
    logic [PAYLOAD_WIDTH-1:0] best_pay_reg;
    logic                     out_valid_reg;
    logic                     found_reg;
    logic [STAMP_W-1:0]       out_stamp_reg;
    logic [PAYLOAD_WIDTH-1:0] out_pay_reg;
    logic [RING_LEN_W-1:0]    ring_length_reg;
    logic [AGE_W-1:0]         max_age_reg;

    logic [CW-1:0]            rl_ext;
    logic [CW-1:0]            eff_len;
    logic [PTR_W-1:0]         head_adv;
    logic [PTR_W-1:0]         walk_adv;
    logic [PTR_W-1:0]         best_adv;
    logic                     push_we;
    logic [STAMP_W-1:0]       rd_stamp;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;
    match_t                   match;

    function automatic logic [PTR_W-1:0] adv(
        input logic [PTR_W-1:0] p,
        input logic [CW-1:0]    len
    );
        logic [CW-1:0] n;
        begin
            n = CW'(p) + CW'(1);
            return (n >= len) ? '0 : PTR_W'(n);
        end
    endfunction

    always_comb
    begin
        rl_ext = CW'(ring_length_reg);
        if (rl_ext == '0)
        begin
            eff_len = CW'(1);
        end
        else if (rl_ext > CW'(DEPTH))
        begin
            eff_len = CW'(DEPTH);
        end
        else
        begin
            eff_len = rl_ext;
        end
    end

    assign head_adv = adv(head_reg, eff_len);
    assign walk_adv = adv(walk_reg, eff_len);
    assign best_adv = adv(best_reg, eff_len);
    assign push_we  = (state_reg == S_EXEC) && (act_reg == ACT_PUSH);

    trr_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (push_we),
        .waddr (head_adv),
        .wdata (stamp_in_reg),
        .raddr (walk_reg),
        .rdata (rd_stamp)
    );

    trr_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (push_we),
        .waddr (head_adv),
        .wdata (pay_in_reg),
        .raddr (walk_reg),
        .rdata (rd_pay)
    );

    trr_match u_match (
        .stamp       (rd_stamp),
        .stamp_valid (valid_reg[walk_reg]),
        .query       (qt_reg),
        .max_age     (max_age_reg),
        .result      (match)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign out_stamp_ms = out_stamp_reg;
    assign out_payload  = out_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            act_reg         <= '0;
            stamp_in_reg    <= '0;
            pay_in_reg      <= '0;
            qt_reg          <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            walk_reg        <= '0;
            cnt_reg         <= '0;
            best_reg        <= '0;
            hit_reg         <= 1'b0;
            single_reg      <= 1'b0;
            flag_reg        <= 1'b0;
            valid_reg       <= '0;
            best_stamp_reg  <= '0;
            best_pay_reg    <= '0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            out_stamp_reg   <= '0;
            out_pay_reg     <= '0;
            ring_length_reg <= RING_LEN_RESET;
            max_age_reg     <= MAX_AGE_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_RING_LENGTH: ring_length_reg <= cfg_data[RING_LEN_W-1:0];
                    REG_MAX_AGE:     max_age_reg     <= cfg_data[AGE_W-1:0];
                    default:         ;
                endcase
            end

            // in S_DONE the output register is reloaded below
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg      <= action;
                        stamp_in_reg <= stamp_ms;
                        pay_in_reg   <= payload;
                        qt_reg       <= query_time_ms;
                        state_reg    <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    hit_reg   <= 1'b0;
                    state_reg <= S_DONE;
                    unique case (act_reg)
                        ACT_PUSH:
                        begin
                            valid_reg[head_adv] <= 1'b1;
                            head_reg            <= head_adv;
                            flag_reg            <= 1'b1;
                        end
                        ACT_CLEAR:
                        begin
                            valid_reg <= '0;
                            head_reg  <= '0;
                            tail_reg  <= '0;
                            flag_reg  <= 1'b0;
                        end
                        ACT_RECALL:
                        begin
                            if (flag_reg)
                            begin
                                walk_reg   <= tail_reg;
                                cnt_reg    <= '0;
                                single_reg <= (head_reg == tail_reg);
                                state_reg  <= S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (match.accept)
                    begin
                        hit_reg        <= 1'b1;
                        best_reg       <= walk_reg;
                        best_stamp_reg <= rd_stamp;
                        best_pay_reg   <= rd_pay;
                    end
                    if (single_reg || match.later || cnt_reg == PTR_W'(DEPTH - 1)
                        || walk_adv == head_reg)
                    begin
                        state_reg <= S_COMMIT;
                    end
                    else
                    begin
                        walk_reg  <= walk_adv;
                        cnt_reg   <= cnt_reg + PTR_W'(1);
                        state_reg <= S_READ;
                    end
                end
                S_COMMIT:
                begin
                    if (hit_reg)
                    begin
                        tail_reg            <= best_adv;
                        valid_reg[best_reg] <= 1'b0;
                        if (single_reg)
                        begin
                            flag_reg <= 1'b0;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= hit_reg;
                        out_stamp_reg <= hit_reg ? best_stamp_reg : '0;
                        out_pay_reg   <= hit_reg ? best_pay_reg : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TRR_ASSERT_IMP(a_ptr_range, 1'b1, (CW'(head_reg) < CW'(DEPTH)) && (CW'(tail_reg) < CW'(DEPTH)))
    `TRR_ASSERT_IMP(a_found_stamp, out_valid_reg && found_reg, out_stamp_reg != '0)
    `TRR_ASSERT_NEXT(a_push_flag, push_we, flag_reg && valid_reg[head_reg])

endmodule

`default_nettype wire
